// File: hdl/ring_buffer_pool_refcount_macros.svh
// Assertion helpers for the buffer pool.
`ifndef RING_BUFFER_POOL_REFCOUNT_MACROS_SVH
`define RING_BUFFER_POOL_REFCOUNT_MACROS_SVH

`ifndef SYNTHESIS
`define RBPR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define RBPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RBPR_ASSERT(lbl, clk, rstn, prop, msg)
`define RBPR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hdl/rbpr_pkg.sv
`timescale 1ns / 1ps

package rbpr_pkg;

  localparam int IDX_W     = 3;
  localparam int CFG_W     = 4;
  localparam int CNT_OUT_W = 8;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [CFG_W-1:0] CFG_POOL_RESET = 4'd8;

  // register word index taken from paddr[2]
  localparam logic REG_BUFFERS_IN_USE = 1'b0;

  localparam logic [1:0] MODE_OBTAIN  = 2'd0;
  localparam logic [1:0] MODE_ADD_REF = 2'd1;
  localparam logic [1:0] MODE_DROP    = 2'd2;
  localparam logic [1:0] MODE_RELEASE = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_POOL_FULL = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] buffer_index;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic [IDX_W-1:0]            granted_index;
    logic signed [CNT_OUT_W-1:0] count_after;
    logic                        buffer_busy;
  } out_beat_t;

  typedef struct packed {
    logic load_in;
    logic exec;
  } ctl_cmd_t;

endpackage

// File: hdl/rbpr_cfg.sv
`timescale 1ns / 1ps

module rbpr_cfg import rbpr_pkg::*; #(
  parameter int POOL_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CFG_W-1:0]   pool_size
);

  localparam int STORE_DEPTH = (POOL_DEPTH < 15) ? POOL_DEPTH : 15;
  localparam logic [CFG_W-1:0] SIZE_MAX = CFG_W'(STORE_DEPTH);

  logic [CFG_W-1:0] buffers_in_use_r, buffers_in_use_nxt;
  logic             hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == REG_BUFFERS_IN_USE);

  always_comb begin
    buffers_in_use_nxt = buffers_in_use_r;
    if (psel && penable && pwrite && pready && hit) begin
      buffers_in_use_nxt = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffers_in_use_r <= CFG_POOL_RESET;
    end else begin
      buffers_in_use_r <= buffers_in_use_nxt;
    end
  end

  assign prdata = hit ? {{(PDATA_W-CFG_W){1'b0}}, buffers_in_use_r} : '0;

  always_comb begin
    priority if (buffers_in_use_r == '0) begin
      pool_size = CFG_W'(1);
    end else if (buffers_in_use_r > SIZE_MAX) begin
      pool_size = SIZE_MAX;
    end else begin
      pool_size = buffers_in_use_r;
    end
  end

endmodule

// File: hdl/rbpr_ctrl.sv
`timescale 1ns / 1ps
`include "ring_buffer_pool_refcount_macros.svh"

module rbpr_ctrl import rbpr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t st_r, st_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready    = (st_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept      = in_valid && in_ready;
  assign cmd.load_in = accept;
  assign cmd.exec    = (st_r == S_EXEC);
  assign out_valid   = out_valid_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (accept) st_nxt = S_EXEC;
      end
      S_EXEC: begin
        st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `RBPR_ASSERT(a_accept_to_exec, clk, rst_n, accept |=> (st_r == S_EXEC), "accept not executed")
  `RBPR_ASSERT(a_exec_slot_free, clk, rst_n, (st_r == S_EXEC) |-> !out_valid_r, "result overwritten")
  `RBPR_ASSERT(a_exec_to_result, clk, rst_n, (st_r == S_EXEC) |=> out_valid_r, "result lost")

endmodule

// File: hdl/rbpr_dp.sv
`timescale 1ns / 1ps

module rbpr_dp import rbpr_pkg::*; #(
  parameter int POOL_DEPTH = 8,
  parameter int COUNT_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_cmd_t         cmd,
  input  in_beat_t         in_data,
  input  logic [CFG_W-1:0] pool_size,
  output out_beat_t        out_data
);

  localparam int STORE_DEPTH = (POOL_DEPTH < 15) ? POOL_DEPTH : 15;
  localparam int PTR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int EXT_W       = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
  localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

  in_beat_t                     in_r;
  out_beat_t                    out_r, out_nxt;
  logic [PTR_W-1:0]             ptr_r, ptr_nxt;
  logic                         used_r   [STORE_DEPTH];
  logic signed [COUNT_BITS-1:0] cnt_r    [STORE_DEPTH];

  logic [PTR_W-1:0]             p, ix, wr_ix;
  logic [CFG_W:0]               p_inc;
  logic                         idx_ok, used_p, wr_en, wr_used;
  logic signed [COUNT_BITS-1:0] cnt_ix, cnt_new, wr_cnt;
  logic signed [EXT_W-1:0]      cnt_ext;

  always_comb begin
    p      = (CFG_W'(ptr_r) >= pool_size) ? '0 : ptr_r;
    p_inc  = (CFG_W+1)'(p) + (CFG_W+1)'(1);
    ix     = PTR_W'(in_r.buffer_index);
    idx_ok = (CFG_W'(in_r.buffer_index) < pool_size);
    used_p = used_r[p];
    cnt_ix = idx_ok ? cnt_r[ix] : '0;

    unique case (in_r.mode)
      MODE_ADD_REF: cnt_new = (cnt_ix == CNT_MAX) ? cnt_ix : cnt_ix + COUNT_BITS'(1);
      default:      cnt_new = (cnt_ix == CNT_MIN) ? cnt_ix : cnt_ix - COUNT_BITS'(1);
    endcase
    cnt_ext = EXT_W'(cnt_new);

    ptr_nxt = ptr_r;
    wr_en   = 1'b0;
    wr_ix   = ix;
    wr_cnt  = cnt_new;
    wr_used = used_r[ix];
    out_nxt = out_r;

    if (cmd.exec) begin
      priority if (in_r.mode == MODE_OBTAIN) begin
        out_nxt.granted_index = IDX_W'(p);
        out_nxt.buffer_busy   = 1'b1;
        if (used_p) begin
          out_nxt.status      = STATUS_POOL_FULL;
          out_nxt.count_after = CNT_OUT_W'(EXT_W'(cnt_r[p]));
        end else begin
          out_nxt.status      = STATUS_OK;
          out_nxt.count_after = '0;
          wr_en   = 1'b1;
          wr_ix   = p;
          wr_cnt  = '0;
          wr_used = 1'b1;
          ptr_nxt = (p_inc >= (CFG_W+1)'(pool_size)) ? '0 : PTR_W'(p_inc);
        end
      end else if (!idx_ok) begin
        out_nxt.status        = STATUS_BAD_INDEX;
        out_nxt.granted_index = in_r.buffer_index;
        out_nxt.count_after   = '0;
        out_nxt.buffer_busy   = 1'b0;
      end else begin
        wr_en = 1'b1;
        if (in_r.mode == MODE_RELEASE && (cnt_new <= 0)) begin
          wr_used = 1'b0;
        end
        out_nxt.status        = STATUS_OK;
        out_nxt.granted_index = in_r.buffer_index;
        out_nxt.count_after   = cnt_ext[CNT_OUT_W-1:0];
        out_nxt.buffer_busy   = wr_used;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        used_r[i] <= 1'b0;
        cnt_r[i]  <= '0;
      end
    end else begin
      ptr_r <= ptr_nxt;
      if (wr_en) begin
        used_r[wr_ix] <= wr_used;
        cnt_r[wr_ix]  <= wr_cnt;
      end
    end
  end

  assign out_data = out_r;

endmodule

// File: hdl/ring_buffer_pool_refcount.sv
`timescale 1ns / 1ps
// Round-robin buffer pool with per-buffer reference counts.
// Input channel (in_valid/in_ready/in_data): one operation per beat,
//   mode = obtain, add reference, drop reference or release, plus a buffer index.
// Result channel (out_valid/out_ready/out_data): one result beat per operation,
//   status, the buffer handed out or acted on, its count and its used mark.
// APB port: one register, buffers_in_use at address 0, written in the access
//   phase, pready tied high; values outside 1..pool depth (at most 15) are clamped.
// Timing: an operation is captured into the input register on acceptance, then
//   the execute state updates the pool state in the register file and loads the
//   result register together; no new operation is accepted until execution is
//   over, so operations do not overlap in the capture/execute sequence.
// Stall: the result register holds its beat while out_ready is low; a new
//   operation is taken once the pending result is taken in the same cycle or
//   has already left.
// Reset (rst_n low, synchronous): pointer to zero, all buffers free, all counts
//   zero, buffers_in_use back to 8, no result pending.
module ring_buffer_pool_refcount import rbpr_pkg::*; #(
  parameter int POOL_DEPTH = 8,
  parameter int COUNT_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_beat_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_beat_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  ctl_cmd_t         cmd;
  logic [CFG_W-1:0] pool_size;

  rbpr_cfg #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pool_size (pool_size)
  );

  rbpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rbpr_dp #(
    .POOL_DEPTH(POOL_DEPTH),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .pool_size (pool_size),
    .out_data  (out_data)
  );

endmodule
